>>> rtl/core/bsa_pkg.sv
// Shared types, codes and helpers for the byte stack ALU.
// No dependencies; used by bsa_alu and byte_stack_alu_top.
`default_nettype none

package bsa_pkg;

    // Default stack capacity in bytes.
    localparam int STACK_BYTES_DEF = 256;

    // Function codes of a request.
    localparam logic [3:0] FN_PUSH = 4'd0;
    localparam logic [3:0] FN_ADD  = 4'd1;
    localparam logic [3:0] FN_SUB  = 4'd2;
    localparam logic [3:0] FN_MUL  = 4'd3;
    localparam logic [3:0] FN_DIV  = 4'd4;
    localparam logic [3:0] FN_SWAP = 4'd5;
    localparam logic [3:0] FN_DUP  = 4'd6;
    localparam logic [3:0] FN_INC  = 4'd7;
    localparam logic [3:0] FN_DEC  = 4'd8;
    localparam logic [3:0] FN_CMP  = 4'd9;
    localparam logic [3:0] FN_NOT  = 4'd10;
    localparam logic [3:0] FN_DROP = 4'd11;

    // Status codes of a result.
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_OVER  = 2'd1;
    localparam logic [1:0] STS_UNDER = 2'd2;
    localparam logic [1:0] STS_DIVZ  = 2'd3;

    // Operations of the shared arithmetic unit.
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_SUB = 3'd1,
        ALU_MUL = 3'd2,
        ALU_DIV = 3'd3,
        ALU_INC = 3'd4,
        ALU_DEC = 3'd5,
        ALU_CMP = 3'd6
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic        done;
        logic [63:0] result;
    } t_alu_rsp;

    // Mask of the operand width selected by a width code.
    function automatic logic [63:0] width_mask(input logic [1:0] code);
        logic [63:0] m;
        unique case (code)
            2'd0: m = 64'h0000_0000_0000_00FF;
            2'd1: m = 64'h0000_0000_0000_FFFF;
            2'd2: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/bsa_alu.sv
// Shared iterative arithmetic unit: one 66-bit adder used for add, sub,
// inc, dec, compare, shift-add multiply and restoring divide. Uses bsa_pkg.
`default_nettype none

module bsa_alu (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bsa_pkg::t_alu_req i_req,
    input  wire logic [63:0]       i_a,
    input  wire logic [63:0]       i_b,
    output bsa_pkg::t_alu_rsp      o_rsp
);

    localparam logic [5:0] LAST_MULTI = 6'd63;

    bsa_pkg::t_alu_op r_op;
    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [64:0]      r_x;
    logic [63:0]      r_a;
    logic [63:0]      r_b;
    logic [63:0]      r_d;
    logic [63:0]      r_res;

    logic [65:0] ad_x;
    logic [65:0] ad_y;
    logic        ad_sub;
    logic [65:0] sum;
    logic [64:0] div_sh;
    logic        qbit;
    logic [63:0] n_res;

    assign div_sh = {r_x[63:0], r_b[63]};

    // Operand selection for the single adder.
    always_comb begin
        ad_x   = {2'b00, r_a};
        ad_y   = {2'b00, r_d};
        ad_sub = 1'b0;
        unique case (r_op)
            bsa_pkg::ALU_ADD: ad_sub = 1'b0;
            bsa_pkg::ALU_SUB: ad_sub = 1'b1;
            bsa_pkg::ALU_INC: ad_y = 66'd1;
            bsa_pkg::ALU_DEC: begin
                ad_y   = 66'd1;
                ad_sub = 1'b1;
            end
            bsa_pkg::ALU_CMP: ad_sub = 1'b1;
            bsa_pkg::ALU_MUL: begin
                ad_x = {1'b0, r_x};
                ad_y = {2'b00, r_a};
            end
            bsa_pkg::ALU_DIV: begin
                ad_x   = {1'b0, div_sh};
                ad_y   = {2'b00, r_d};
                ad_sub = 1'b1;
            end
            default: ad_sub = 1'b0;
        endcase
    end

    assign sum  = ad_x + (ad_sub ? ~ad_y : ad_y) + {65'd0, ad_sub};
    assign qbit = ~sum[65];

    // Result of the final step.
    always_comb begin
        unique case (r_op)
            bsa_pkg::ALU_MUL: n_res = r_b[0] ? sum[63:0] : r_x[63:0];
            bsa_pkg::ALU_DIV: n_res = {r_b[62:0], qbit};
            bsa_pkg::ALU_CMP: begin
                if (sum[65]) begin
                    n_res = 64'h0000_0000_0000_00FF;
                end else if (sum[64:0] == 65'd0) begin
                    n_res = 64'd0;
                end else begin
                    n_res = 64'd1;
                end
            end
            default: n_res = sum[63:0];
        endcase
    end

    // Sequencer of the unit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 6'd0;
            r_op   <= bsa_pkg::ALU_ADD;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_op   <= i_req.op;
                r_busy <= 1'b1;
                r_a    <= i_a;
                r_d    <= i_b;
                r_b    <= (i_req.op == bsa_pkg::ALU_DIV) ? i_a : i_b;
                r_x    <= 65'd0;
                r_cnt  <= (i_req.op == bsa_pkg::ALU_MUL || i_req.op == bsa_pkg::ALU_DIV)
                          ? LAST_MULTI : 6'd0;
            end else if (r_busy) begin
                if (r_op == bsa_pkg::ALU_MUL) begin
                    if (r_b[0]) begin
                        r_x <= sum[64:0];
                    end
                    r_a <= {r_a[62:0], 1'b0};
                    r_b <= {1'b0, r_b[63:1]};
                end else if (r_op == bsa_pkg::ALU_DIV) begin
                    r_x <= qbit ? sum[64:0] : div_sh;
                    r_b <= {r_b[62:0], qbit};
                end
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    r_res  <= n_res;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_res;

endmodule

`default_nettype wire

>>> rtl/core/byte_stack_alu_top.sv
// Top level of the byte stack ALU: stack memory, sequencer and output register.
// Depends on bsa_pkg and bsa_alu.
//
//  Channel   Direction  Handshake                  Payload
//  request   in         i_in_valid / o_in_stall    i_func, i_width_code, i_literal
//  result    out        o_out_valid / i_out_stall  o_status, o_value_out, o_depth
//
// A request runs through the read, operate, write and finish states from one acceptance
// to the next; the stack memory moves one byte per cycle in the read and write states,
// so their length follows the bytes read and written; add, sub, inc, dec and compare
// also wait for the arithmetic unit between the operate and write states.
// Multiply and divide wait longer there, as the bit-serial arithmetic unit steps bit by bit.
// Errors found on the stack pointer alone go straight to the finish state.
// Reset clears the stack pointer, state and output valid; no clearing pass runs over the memory.
// A result waits in the output register under stall; the next request is taken meanwhile.
`default_nettype none

module byte_stack_alu_top #(
    parameter int STACK_BYTES = bsa_pkg::STACK_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [3:0]  i_func,
    input  wire logic [1:0]  i_width_code,
    input  wire logic [63:0] i_literal,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_status,
    output logic [63:0]      o_value_out,
    output logic [7:0]       o_depth
);

    localparam int SPW = $clog2(STACK_BYTES);
    localparam logic [SPW:0] CAP = (SPW + 1)'(STACK_BYTES);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_READ  = 6'b000010,
        ST_OPER  = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_FIN   = 6'b100000
    } t_state;

    t_state           r_state;
    logic [SPW-1:0]   r_sp;
    logic [SPW-1:0]   r_new_sp;
    logic [3:0]       r_func;
    logic [1:0]       r_wcode;
    logic [3:0]       r_w;
    logic [4:0]       r_cnt;
    logic [4:0]       r_nread;
    logic [4:0]       r_nwrite;
    logic [SPW-1:0]   r_rbase_t;
    logic [SPW-1:0]   r_rbase_b;
    logic [SPW-1:0]   r_wbase;
    logic [63:0]      r_top;
    logic [63:0]      r_bel;
    logic [63:0]      r_wlo;
    logic [63:0]      r_whi;
    logic [63:0]      r_val;
    logic [1:0]       r_status;
    logic             r_rd_pend;
    logic [4:0]       r_rd_idx;
    logic [7:0]       r_rd_data;
    logic             r_o_valid;
    logic [1:0]       r_o_status;
    logic [63:0]      r_o_value;
    logic [SPW-1:0]   r_o_sp;

    logic [7:0]       mem [STACK_BYTES];

    logic [3:0]       acc_w;
    logic [SPW:0]     sp_x;
    logic [SPW:0]     w_x;
    logic [SPW:0]     w2_x;
    logic             rd_issue;
    logic [4:0]       rd_off;
    logic [SPW-1:0]   rd_addr;
    logic             wr_en;
    logic [4:0]       wr_off;
    logic [SPW-1:0]   wr_addr;
    logic [7:0]       wr_data;
    logic [4:0]       pl_off;
    logic [63:0]      mask;
    logic [SPW+7:0]   depth_x;
    bsa_pkg::t_alu_req alu_req;
    bsa_pkg::t_alu_rsp alu_rsp;

    // Width of the request in bytes; NOT always works on one byte.
    assign acc_w = (i_func == bsa_pkg::FN_NOT) ? 4'd1 : (4'd1 << i_width_code);
    assign sp_x  = {1'b0, r_sp};
    assign w_x   = (SPW + 1)'(acc_w);
    assign w2_x  = (SPW + 1)'({acc_w, 1'b0});
    assign mask  = (r_func == bsa_pkg::FN_NOT) ? bsa_pkg::width_mask(2'd0)
                                                : bsa_pkg::width_mask(r_wcode);

    // Read address: top item bytes first, then the item below.
    assign rd_issue = (r_state == ST_READ) && (r_cnt < r_nread);
    assign rd_off   = r_cnt - {1'b0, r_w};
    assign rd_addr  = (r_cnt < {1'b0, r_w}) ? r_rbase_t + SPW'(r_cnt)
                                             : r_rbase_b + SPW'(rd_off);

    // Write address and data byte.
    assign wr_en   = (r_state == ST_WRITE) && (r_cnt < r_nwrite);
    assign wr_off  = r_cnt - {1'b0, r_w};
    assign wr_addr = r_wbase + SPW'(r_cnt);
    assign wr_data = (r_cnt < {1'b0, r_w}) ? r_wlo[8*r_cnt[2:0] +: 8]
                                            : r_whi[8*wr_off[2:0] +: 8];

    assign pl_off = r_rd_idx - {1'b0, r_w};

    // Stack memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    // Arithmetic start request.
    always_comb begin
        alu_req.start = 1'b0;
        alu_req.op    = bsa_pkg::ALU_ADD;
        if (r_state == ST_OPER) begin
            unique case (r_func)
                bsa_pkg::FN_ADD: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = bsa_pkg::ALU_ADD;
                end
                bsa_pkg::FN_SUB: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = bsa_pkg::ALU_SUB;
                end
                bsa_pkg::FN_MUL: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = bsa_pkg::ALU_MUL;
                end
                bsa_pkg::FN_DIV: begin
                    alu_req.start = (r_bel != 64'd0);
                    alu_req.op    = bsa_pkg::ALU_DIV;
                end
                bsa_pkg::FN_INC: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = bsa_pkg::ALU_INC;
                end
                bsa_pkg::FN_DEC: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = bsa_pkg::ALU_DEC;
                end
                bsa_pkg::FN_CMP: begin
                    alu_req.start = 1'b1;
                    alu_req.op    = bsa_pkg::ALU_CMP;
                end
                default: alu_req.start = 1'b0;
            endcase
        end
    end

    bsa_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (alu_req),
        .i_a     (r_top),
        .i_b     (r_bel),
        .o_rsp   (alu_rsp)
    );

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_rd_pend <= rd_issue;
            r_rd_idx  <= r_cnt;
            if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end

            // Place a returned byte into the top or the lower item.
            if (r_rd_pend) begin
                if (r_rd_idx < {1'b0, r_w}) begin
                    r_top[8*r_rd_idx[2:0] +: 8] <= r_rd_data;
                end else begin
                    r_bel[8*pl_off[2:0] +: 8] <= r_rd_data;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_func    <= i_func;
                        r_wcode   <= i_width_code;
                        r_w       <= acc_w;
                        r_cnt     <= 5'd0;
                        r_top     <= 64'd0;
                        r_bel     <= 64'd0;
                        r_whi     <= 64'd0;
                        r_val     <= 64'd0;
                        r_status  <= bsa_pkg::STS_OK;
                        r_new_sp  <= r_sp;
                        r_nread   <= 5'd0;
                        r_nwrite  <= 5'd0;
                        r_rbase_t <= r_sp - SPW'(acc_w);
                        r_rbase_b <= r_sp - SPW'({acc_w, 1'b0});
                        r_wbase   <= r_sp;
                        r_state   <= ST_READ;
                        unique case (i_func)
                            bsa_pkg::FN_PUSH: begin
                                if (sp_x + w_x >= CAP) begin
                                    r_status <= bsa_pkg::STS_OVER;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_wlo    <= i_literal & bsa_pkg::width_mask(i_width_code);
                                    r_val    <= i_literal & bsa_pkg::width_mask(i_width_code);
                                    r_nwrite <= {1'b0, acc_w};
                                    r_new_sp <= r_sp + SPW'(acc_w);
                                end
                            end
                            bsa_pkg::FN_ADD, bsa_pkg::FN_SUB, bsa_pkg::FN_MUL,
                            bsa_pkg::FN_DIV: begin
                                if (sp_x < w2_x) begin
                                    r_status <= bsa_pkg::STS_UNDER;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_nread  <= {acc_w, 1'b0};
                                    r_nwrite <= {1'b0, acc_w};
                                    r_wbase  <= r_sp - SPW'({acc_w, 1'b0});
                                    r_new_sp <= r_sp - SPW'(acc_w);
                                end
                            end
                            bsa_pkg::FN_SWAP: begin
                                if (sp_x < w2_x) begin
                                    r_status <= bsa_pkg::STS_UNDER;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_nread  <= {acc_w, 1'b0};
                                    r_nwrite <= {acc_w, 1'b0};
                                    r_wbase  <= r_sp - SPW'({acc_w, 1'b0});
                                end
                            end
                            bsa_pkg::FN_DUP: begin
                                if (sp_x < w_x) begin
                                    r_status <= bsa_pkg::STS_UNDER;
                                    r_state  <= ST_FIN;
                                end else if (sp_x + w_x >= CAP) begin
                                    r_status <= bsa_pkg::STS_OVER;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_nread  <= {1'b0, acc_w};
                                    r_nwrite <= {1'b0, acc_w};
                                    r_new_sp <= r_sp + SPW'(acc_w);
                                end
                            end
                            bsa_pkg::FN_INC, bsa_pkg::FN_DEC, bsa_pkg::FN_NOT: begin
                                if (sp_x < w_x) begin
                                    r_status <= bsa_pkg::STS_UNDER;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_nread  <= {1'b0, acc_w};
                                    r_nwrite <= {1'b0, acc_w};
                                    r_wbase  <= r_sp - SPW'(acc_w);
                                end
                            end
                            bsa_pkg::FN_CMP: begin
                                if (sp_x < w2_x) begin
                                    r_status <= bsa_pkg::STS_UNDER;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_nread  <= {acc_w, 1'b0};
                                    r_nwrite <= 5'd1;
                                    r_wbase  <= r_sp - SPW'(acc_w);
                                    r_new_sp <= r_sp - SPW'(acc_w) + SPW'(1);
                                end
                            end
                            bsa_pkg::FN_DROP: begin
                                if (sp_x < w_x) begin
                                    r_status <= bsa_pkg::STS_UNDER;
                                    r_state  <= ST_FIN;
                                end else begin
                                    r_nread  <= {1'b0, acc_w};
                                    r_new_sp <= r_sp - SPW'(acc_w);
                                end
                            end
                            default: r_state <= ST_FIN;
                        endcase
                    end
                end
                ST_READ: begin
                    if (rd_issue) begin
                        r_cnt <= r_cnt + 5'd1;
                    end else begin
                        r_state <= ST_OPER;
                    end
                end
                ST_OPER: begin
                    r_cnt <= 5'd0;
                    if (alu_req.start) begin
                        r_state <= ST_WAIT;
                    end else if (r_func == bsa_pkg::FN_DIV) begin
                        r_status <= bsa_pkg::STS_DIVZ;
                        r_new_sp <= r_sp;
                        r_state  <= ST_FIN;
                    end else begin
                        r_state <= ST_WRITE;
                        unique case (r_func)
                            bsa_pkg::FN_SWAP: begin
                                r_wlo <= r_top;
                                r_whi <= r_bel;
                                r_val <= r_bel;
                            end
                            bsa_pkg::FN_NOT: begin
                                r_wlo <= (r_top == 64'd0) ? 64'd1 : 64'd0;
                                r_val <= (r_top == 64'd0) ? 64'd1 : 64'd0;
                            end
                            bsa_pkg::FN_DUP, bsa_pkg::FN_DROP: begin
                                r_wlo <= r_top;
                                r_val <= r_top;
                            end
                            default: r_wlo <= r_wlo;
                        endcase
                    end
                end
                ST_WAIT: begin
                    if (alu_rsp.done) begin
                        r_wlo   <= alu_rsp.result & mask;
                        r_val   <= alu_rsp.result & mask;
                        r_state <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    if (wr_en) begin
                        r_cnt <= r_cnt + 5'd1;
                    end else begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!r_o_valid || !i_out_stall) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= r_status;
                        r_o_value  <= (r_status == bsa_pkg::STS_OK) ? r_val : 64'd0;
                        r_o_sp     <= r_new_sp;
                        r_sp       <= r_new_sp;
                        r_state    <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign depth_x     = {8'd0, r_o_sp};
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_status    = r_o_status;
    assign o_value_out = r_o_value;
    assign o_depth     = depth_x[7:0];

    // The stack pointer always stays below the capacity.
    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sp_x < CAP)
        else $error("stack pointer reached capacity");

    // The memory is written only in the write phase of a request.
    a_wr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == ST_WRITE) && (r_status == bsa_pkg::STS_OK))
        else $error("stack write outside the write phase");

    // A failed request leaves the stack pointer as it was.
    a_err_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) && (r_status != bsa_pkg::STS_OK) |-> (r_new_sp == r_sp))
        else $error("error changed the stack pointer");

    // The arithmetic unit reports completion only while it is awaited.
    a_alu_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alu_rsp.done |-> (r_state == ST_WAIT))
        else $error("arithmetic completion outside wait state");

endmodule

`default_nettype wire
